// ===== rtl/core/nmea_numeric_field_parser_unit_defines.svh =====
// ----------------------------------------------------------------------------
// NMEA numeric field parser assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef NMEA_NUMERIC_FIELD_PARSER_UNIT_DEFINES_SVH
`define NMEA_NUMERIC_FIELD_PARSER_UNIT_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define NNFP_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define NNFP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The condition never holds.
`define NNFP_ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== rtl/core/nnfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA numeric field parser package
// Shared constants, codes, the field record passed from front to back end,
// and the power-of-ten table used for the fraction conversion.
// ----------------------------------------------------------------------------
package nnfp_pkg;

    // Fraction digits kept and fraction bits produced before alignment.
    localparam int FRAC_DIGITS = 9;
    localparam int FRAC_BITS   = 32;

    // Depth of the queue between front and back end.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Field kinds.
    localparam logic [1:0] KIND_LAT = 2'd0;
    localparam logic [1:0] KIND_LON = 2'd1;
    localparam logic [1:0] KIND_DEC = 2'd2;
    localparam logic [1:0] KIND_INT = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;

    // Character codes.
    localparam logic [7:0] CH_END   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Everything the back end needs to finish one field.
    typedef struct packed {
        logic [1:0]  kind;
        logic        bad;
        logic        negative;
        logic        short_int;
        logic        overflow;
        logic [31:0] whole;
        logic [29:0] frac;
        logic [3:0]  frac_cnt;
    } t_field;

    // Ten to the power n, saturating at ten to the ninth.
    function automatic logic [29:0] pow10(input logic [3:0] n);
        logic [29:0] v;
        case (n)
            4'd0:    v = 30'd1;
            4'd1:    v = 30'd10;
            4'd2:    v = 30'd100;
            4'd3:    v = 30'd1000;
            4'd4:    v = 30'd10000;
            4'd5:    v = 30'd100000;
            4'd6:    v = 30'd1000000;
            4'd7:    v = 30'd10000000;
            4'd8:    v = 30'd100000000;
            default: v = 30'd1000000000;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/nnfp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA numeric field parser front end
// Scans one character per beat, accumulates the integer and fraction digits,
// and pushes a field record into the queue when the end character arrives.
// ----------------------------------------------------------------------------
module nnfp_front
    import nnfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_ch,
    input  logic [1:0]  i_field_kind,
    input  logic        i_q_full,
    output logic        o_stall,
    output logic        o_push,
    output t_field      o_entry
);

    // Scan phases.
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_LEAD = 3'd1;
    localparam logic [2:0] PH_INT  = 3'd2;
    localparam logic [2:0] PH_FRAC = 3'd3;
    localparam logic [2:0] PH_TAIL = 3'd4;
    localparam logic [2:0] PH_BAD  = 3'd5;

    logic [2:0]  r_phase, n_phase;
    logic [1:0]  r_kind, n_kind;
    logic        r_neg, n_neg;
    logic [31:0] r_whole, n_whole;
    logic        r_ovf, n_ovf;
    logic [3:0]  r_int_cnt, n_int_cnt;
    logic [29:0] r_frac, n_frac;
    logic [3:0]  r_frac_cnt, n_frac_cnt;

    logic        w_accept;
    logic        w_end;
    logic [2:0]  w_phase;
    logic [1:0]  w_kind;
    logic        w_coord;
    logic        w_digit;
    logic [3:0]  w_dig;
    logic [35:0] w_int_prod;
    logic [33:0] w_frac_prod;
    logic        w_do_int;

    // A beat is taken unless the queue is full.
    assign o_stall  = i_q_full;
    assign w_accept = i_valid && !i_q_full;
    assign w_end    = (i_ch == CH_END);
    assign o_push   = w_accept && w_end;

    // The first character of a field samples the kind and opens the field.
    assign w_phase = (r_phase == PH_IDLE) ? PH_LEAD : r_phase;
    assign w_kind  = (r_phase == PH_IDLE) ? i_field_kind : r_kind;
    assign w_coord = (w_kind == KIND_LAT) || (w_kind == KIND_LON);
    assign w_digit = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign w_dig   = 4'(i_ch - CH_ZERO);

    // Times ten plus digit, as shift and add.
    assign w_int_prod  = 36'({r_whole, 3'b000}) + 36'({r_whole, 1'b0}) + 36'(w_dig);
    assign w_frac_prod = 34'({r_frac, 3'b000}) + 34'({r_frac, 1'b0}) + 34'(w_dig);

    // Field record, taken at the end character.
    assign o_entry.kind      = w_kind;
    assign o_entry.bad       = (w_phase == PH_BAD);
    assign o_entry.negative  = r_neg;
    assign o_entry.short_int = (r_int_cnt < 4'd3);
    assign o_entry.overflow  = r_ovf;
    assign o_entry.whole     = r_whole;
    assign o_entry.frac      = r_frac;
    assign o_entry.frac_cnt  = r_frac_cnt;

    // Character scanner.
    always_comb begin
        n_phase    = w_phase;
        n_kind     = w_kind;
        n_neg      = r_neg;
        n_whole    = r_whole;
        n_ovf      = r_ovf;
        n_int_cnt  = r_int_cnt;
        n_frac     = r_frac;
        n_frac_cnt = r_frac_cnt;
        w_do_int   = 1'b0;

        case (w_phase)
            PH_LEAD: begin
                if ((i_ch == CH_SPACE) || (i_ch == CH_TAB)) begin
                    n_phase = PH_LEAD;
                end else if ((i_ch == CH_MINUS) && !w_coord) begin
                    n_neg   = 1'b1;
                    n_phase = PH_INT;
                end else begin
                    w_do_int = 1'b1;
                end
            end
            PH_INT: begin
                w_do_int = 1'b1;
            end
            PH_FRAC: begin
                if (w_digit) begin
                    if (r_frac_cnt < 4'(FRAC_DIGITS)) begin
                        n_frac     = w_frac_prod[29:0];
                        n_frac_cnt = r_frac_cnt + 4'd1;
                    end
                end else begin
                    n_phase = w_coord ? PH_TAIL : PH_BAD;
                end
            end
            default: begin
            end
        endcase

        // Integer part handling, shared by the lead and integer phases.
        if (w_do_int) begin
            if (w_digit) begin
                n_phase = PH_INT;
                n_whole = w_int_prod[31:0];
                if (w_int_prod[35:32] != 4'd0) begin
                    n_ovf = 1'b1;
                end
                if (r_int_cnt != 4'd15) begin
                    n_int_cnt = r_int_cnt + 4'd1;
                end
            end else if ((i_ch == CH_DOT) && (w_kind != KIND_INT)) begin
                n_phase = PH_FRAC;
            end else begin
                n_phase = w_coord ? PH_TAIL : PH_BAD;
            end
        end

        // The end character closes the field and clears the scanner.
        if (w_end) begin
            n_phase    = PH_IDLE;
            n_kind     = KIND_LAT;
            n_neg      = 1'b0;
            n_whole    = '0;
            n_ovf      = 1'b0;
            n_int_cnt  = '0;
            n_frac     = '0;
            n_frac_cnt = '0;
        end
    end

    // Scanner state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_kind     <= KIND_LAT;
            r_neg      <= 1'b0;
            r_whole    <= '0;
            r_ovf      <= 1'b0;
            r_int_cnt  <= '0;
            r_frac     <= '0;
            r_frac_cnt <= '0;
        end else if (w_accept) begin
            r_phase    <= n_phase;
            r_kind     <= n_kind;
            r_neg      <= n_neg;
            r_whole    <= n_whole;
            r_ovf      <= n_ovf;
            r_int_cnt  <= n_int_cnt;
            r_frac     <= n_frac;
            r_frac_cnt <= n_frac_cnt;
        end
    end

endmodule

// ===== rtl/core/nnfp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA numeric field parser record queue
// A short first-in first-out buffer of field records that decouples the
// character scanner from the conversion back end. The head record is read
// through a register and is valid the cycle after it is popped.
// ----------------------------------------------------------------------------
module nnfp_queue
    import nnfp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_field i_entry,
    input  logic   i_pop,
    output t_field o_entry,
    output logic   o_full,
    output logic   o_empty
);

    t_field              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QCNT_W-1:0]   r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);

    // Record storage; the head slot is sampled every cycle.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
        o_entry <= r_mem[r_rd];
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/core/nnfp_back.sv =====
`timescale 1ns / 1ps
`include "nmea_numeric_field_parser_unit_defines.svh"
// ----------------------------------------------------------------------------
// NMEA numeric field parser back end
// Turns a field record into a result: reciprocal multiplications split
// degrees from minutes and divide the minutes by sixty, a bit-serial divider
// converts the decimal fraction to binary; a result register holds the beat
// for the consumer.
// ----------------------------------------------------------------------------
module nnfp_back
    import nnfp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_field             i_entry,
    input  logic               i_empty,
    output logic               o_pop,
    input  logic               i_stall,
    output logic               o_valid,
    output logic signed [63:0] o_fixed_value,
    output logic signed [31:0] o_int_value,
    output logic [1:0]         o_status
);

    // Sequencer states.
    localparam logic [3:0] B_IDLE  = 4'd0;
    localparam logic [3:0] B_LOAD  = 4'd1;
    localparam logic [3:0] B_SETUP = 4'd2;
    localparam logic [3:0] B_D100  = 4'd3;
    localparam logic [3:0] B_CHECK = 4'd4;
    localparam logic [3:0] B_FRAC  = 4'd5;
    localparam logic [3:0] B_FEND  = 4'd6;
    localparam logic [3:0] B_D60   = 4'd7;
    localparam logic [3:0] B_CEND  = 4'd8;
    localparam logic [3:0] B_DONE  = 4'd9;

    // Reciprocals: 2^19 / 100 and 2^35 / 15 rounded up, 2^32 / 60 truncated.
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam logic [31:0] RECIP_15  = 32'h8888_8889;
    localparam logic [31:0] MIN_STEP  = 32'd71582788;

    logic [3:0]  r_state;
    t_field      r_ent;
    logic [29:0] r_rem;
    logic [31:0] r_sh;
    logic [29:0] r_div;
    logic [5:0]  r_cnt;
    logic [7:0]  r_deg;
    logic [6:0]  r_min;
    logic [63:0] r_res_fixed;
    logic [31:0] r_res_int;
    logic [1:0]  r_res_status;
    logic        r_out_valid;
    logic [63:0] r_out_fixed;
    logic [31:0] r_out_int;
    logic [1:0]  r_out_status;

    logic        w_busy_div;
    logic [30:0] w_trial;
    logic        w_ge;
    logic [29:0] w_rem_next;
    logic        w_last;
    logic [7:0]  w_lim;
    logic [31:0] w_coord_max;
    logic        w_coord_wide;
    logic [14:0] w_whole15;
    logic [27:0] w_deg_prod;
    logic [14:0] w_min;
    logic        w_coord_fail;
    logic [31:0] w_frac32;
    logic [31:0] w_q60_in;
    logic [63:0] w_q15_prod;
    logic [31:0] w_min_term;
    logic [63:0] w_mag;
    logic        w_exceed;
    logic        w_dec_range;
    logic        w_load_out;
    logic        w_status_undef;

    assign o_pop         = (r_state == B_IDLE) && !i_empty;
    assign o_valid       = r_out_valid;
    assign o_fixed_value = r_out_fixed;
    assign o_int_value   = r_out_int;
    assign o_status      = r_out_status;

    // One restoring division step: shift in a dividend bit, subtract if it fits.
    assign w_busy_div = (r_state == B_FRAC);
    assign w_trial    = {r_rem, r_sh[31]};
    assign w_ge       = (w_trial >= {1'b0, r_div});
    assign w_rem_next = w_ge ? 30'(w_trial - {1'b0, r_div}) : w_trial[29:0];
    assign w_last     = (r_cnt == 6'(FRAC_BITS - 1));

    // Coordinates above ddd59 fail outright; below that the integer part fits
    // 15 bits and degrees come from a reciprocal multiplication by 1/100.
    assign w_lim        = (r_ent.kind == KIND_LAT) ? 8'd90 : 8'd180;
    assign w_coord_max  = (r_ent.kind == KIND_LAT) ? 32'd9059 : 32'd18059;
    assign w_coord_wide = (r_ent.whole > w_coord_max);
    assign w_whole15    = r_ent.whole[14:0];
    assign w_deg_prod   = {13'd0, w_whole15} * {15'd0, RECIP_100};
    assign w_min        = w_whole15 - ({7'd0, r_deg} * 15'd100);

    // Coordinate range check on degrees and minutes.
    assign w_coord_fail = (r_deg > w_lim) || (w_min > 15'd59)
                        || ((r_deg == w_lim)
                            && ((w_min != 15'd0) || (r_ent.frac != 30'd0)));

    // Fraction aligned to 32 bits, and the decimal magnitude with its limit.
    assign w_frac32    = r_sh << (32 - FRAC_BITS);
    assign w_mag       = {r_ent.whole, w_frac32};
    assign w_exceed    = r_ent.negative ? (w_mag[63] && (w_mag[62:0] != 63'd0)) : w_mag[63];
    assign w_dec_range = r_ent.overflow || w_exceed;

    // Minutes over sixty: min * 2^32 / 60 splits into min * MIN_STEP plus
    // (16 * min + fraction) / 60, which is taken as a quarter divided by 15.
    assign w_q60_in   = {23'd0, r_min, 2'b00} + {2'b00, w_frac32[31:2]};
    assign w_q15_prod = {32'd0, r_sh} * {32'd0, RECIP_15};
    assign w_min_term = {25'd0, r_min} * MIN_STEP;

    assign w_load_out = (r_state == B_DONE) && (!r_out_valid || !i_stall);

    assign w_status_undef = (r_out_status != ST_OK) && (r_out_status != ST_MALFORMED)
                          && (r_out_status != ST_RANGE);

    // Conversion sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            case (r_state)
                B_IDLE: begin
                    if (o_pop) begin
                        r_state <= B_LOAD;
                    end
                end
                B_LOAD: begin
                    // The popped record is on the queue output this cycle.
                    r_ent   <= i_entry;
                    r_state <= B_SETUP;
                end
                B_SETUP: begin
                    r_res_fixed <= '0;
                    r_res_int   <= '0;
                    r_cnt       <= '0;
                    case (r_ent.kind)
                        KIND_LAT, KIND_LON: begin
                            if (r_ent.short_int) begin
                                r_res_status <= ST_MALFORMED;
                                r_state      <= B_DONE;
                            end else if (r_ent.overflow || w_coord_wide) begin
                                r_res_status <= ST_RANGE;
                                r_state      <= B_DONE;
                            end else begin
                                r_state <= B_D100;
                            end
                        end
                        KIND_DEC: begin
                            r_rem   <= r_ent.frac;
                            r_sh    <= '0;
                            r_div   <= pow10(r_ent.frac_cnt);
                            r_state <= B_FRAC;
                        end
                        default: begin
                            r_res_int    <= r_ent.negative ? (32'd0 - r_ent.whole)
                                                           : r_ent.whole;
                            r_res_status <= r_ent.bad ? ST_MALFORMED : ST_OK;
                            r_state      <= B_DONE;
                        end
                    endcase
                end
                B_D100: begin
                    r_deg   <= w_deg_prod[26:19];
                    r_state <= B_CHECK;
                end
                B_FRAC: begin
                    r_rem <= w_rem_next;
                    r_sh  <= {r_sh[30:0], w_ge};
                    r_cnt <= r_cnt + 6'd1;
                    if (w_last) begin
                        r_state <= B_FEND;
                    end
                end
                B_CHECK: begin
                    if (w_coord_fail) begin
                        r_res_status <= ST_RANGE;
                        r_state      <= B_DONE;
                    end else begin
                        r_min   <= w_min[6:0];
                        r_rem   <= r_ent.frac;
                        r_sh    <= '0;
                        r_div   <= pow10(r_ent.frac_cnt);
                        r_cnt   <= '0;
                        r_state <= B_FRAC;
                    end
                end
                B_FEND: begin
                    if (r_ent.kind == KIND_DEC) begin
                        r_res_status <= r_ent.bad ? ST_MALFORMED
                                      : (w_dec_range ? ST_RANGE : ST_OK);
                        r_res_fixed  <= w_dec_range ? 64'd0
                                      : (r_ent.negative ? (64'd0 - w_mag) : w_mag);
                        r_state      <= B_DONE;
                    end else begin
                        r_sh    <= w_q60_in;
                        r_state <= B_D60;
                    end
                end
                B_D60: begin
                    r_sh    <= {3'd0, w_q15_prod[63:35]};
                    r_state <= B_CEND;
                end
                B_CEND: begin
                    r_res_fixed  <= {24'd0, r_deg, r_sh + w_min_term};
                    r_res_status <= ST_OK;
                    r_state      <= B_DONE;
                end
                B_DONE: begin
                    if (w_load_out) begin
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    // Result register toward the consumer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_fixed  <= r_res_fixed;
            r_out_int    <= r_res_int;
            r_out_status <= r_res_status;
        end
    end

    // The divider remainder stays below the divisor on every step.
    `NNFP_ASSERT_IMPL(a_rem_below_div, w_busy_div, r_rem < r_div, "divider remainder out of range")
    // A coordinate that passed the range check carries at most 180 degrees.
    `NNFP_ASSERT_IMPL(a_deg_bounded, r_state == B_CEND, r_deg <= 8'd180, "degrees exceed limit")
    // Taking a record from the queue always loads it next.
    `NNFP_ASSERT_NEXT(a_pop_to_load, o_pop, r_state == B_LOAD, "popped record not loaded")
    // A delivered result carries a defined status code.
    `NNFP_ASSERT_NEVER(a_status_code, r_out_valid && w_status_undef, "undefined status code")

endmodule

// ===== rtl/core/nmea_numeric_field_parser_unit.sv =====
// After the end character of a field is accepted, its record waits in the queue for
// the back end; an integer is converted directly, a coordinate may be rejected as
// malformed or out of range; others and decimals use the bit-serial fraction divider.
// Throughput: one character per cycle while the two-record queue has room; the back end
// converts one field at a time, so short fields in a row stall the input.
// Reset: synchronous active-low i_rst_n clears the scanner, queue and sequencer.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA numeric field parser unit
// Parses latitude, longitude, decimal and integer NMEA fields one character
// per beat and delivers one Q31.32 or integer result per field.
// ----------------------------------------------------------------------------
module nmea_numeric_field_parser_unit
    import nnfp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_ch,
    input  logic [1:0]         i_field_kind,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [63:0] o_fixed_value,
    output logic signed [31:0] o_int_value,
    output logic [1:0]         o_status
);

    logic   w_q_full;
    logic   w_q_empty;
    logic   w_push;
    logic   w_pop;
    t_field w_push_entry;
    t_field w_head_entry;

    // Character scanner.
    nnfp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_ch         (i_ch),
        .i_field_kind (i_field_kind),
        .i_q_full     (w_q_full),
        .o_stall      (o_in_stall),
        .o_push       (w_push),
        .o_entry      (w_push_entry)
    );

    // Record queue between scanner and converter.
    nnfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_entry (w_head_entry),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    // Conversion back end and result register.
    nnfp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry       (w_head_entry),
        .i_empty       (w_q_empty),
        .o_pop         (w_pop),
        .i_stall       (i_out_stall),
        .o_valid       (o_out_valid),
        .o_fixed_value (o_fixed_value),
        .o_int_value   (o_int_value),
        .o_status      (o_status)
    );

endmodule
